// File: sv/markup_tag_balance_checker_defines.svh
// Assertion macros shared by the markup tag balance checker RTL.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef MARKUP_TAG_BALANCE_CHECKER_DEFINES_SVH
`define MARKUP_TAG_BALANCE_CHECKER_DEFINES_SVH

// same-cycle implication
`define MTB_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mtb: same-cycle check failed");

// next-cycle implication
`define MTB_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mtb: next-cycle check failed");

`endif

// File: sv/mtb_pkg.sv
// Shared types and constants for the markup tag balance checker.
// No dependencies.
package mtb_pkg;

	localparam int MAX_DEPTH_DEF   = 64;
	localparam int MAX_TAG_LEN_DEF = 32;

	localparam logic [7:0] CH_OPEN  = 8'h3C;
	localparam logic [7:0] CH_CLOSE = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_MISMATCH   = 3'd1;
	localparam logic [2:0] ST_UNCLOSED   = 3'd2;
	localparam logic [2:0] ST_INCOMPLETE = 3'd3;
	localparam logic [2:0] ST_DEPTH      = 3'd4;
	localparam logic [2:0] ST_TOOLONG    = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} byte_item_t;

	typedef struct packed {
		logic       balanced;
		logic [2:0] status;
	} result_item_t;

endpackage

// File: sv/markup_tag_balance_checker.sv
// Markup tag balance checker top level: tag parser, tag stack memories, verdict.
// Depends on mtb_pkg, mtb_out_reg and markup_tag_balance_checker_defines.svh.
//
//   channel  signals                                  payload
//   byte     byte_valid / byte_ready / byte_item      data_byte[7:0], last
//   result   result_valid / result_ready / result_item balanced, status[2:0]
//
// One byte per cycle while byte_ready is high; the verdict shows on result in the cycle
// after the last byte's transfer. A closing tag byte reads the stack memory at its
// transfer and is compared in the next cycle, forwarded into the '>' check.
// Reset clears control state only; stack memories need no clearing pass.
// byte_ready drops only while a verdict is held and result_ready is low.
`include "markup_tag_balance_checker_defines.svh"

module markup_tag_balance_checker
	import mtb_pkg::*;
#(
	parameter int MAX_DEPTH   = MAX_DEPTH_DEF,
	parameter int MAX_TAG_LEN = MAX_TAG_LEN_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         byte_valid,
	output logic         byte_ready,
	input  byte_item_t   byte_item,
	output logic         result_valid,
	input  logic         result_ready,
	output result_item_t result_item
);

	localparam int IDX_W  = $clog2(MAX_TAG_LEN + 1);
	localparam int DEP_W  = $clog2(MAX_DEPTH + 1);
	localparam int TOP_W  = $clog2(MAX_DEPTH);
	localparam int NBYTES = MAX_DEPTH * MAX_TAG_LEN;
	localparam int ADDR_W = $clog2(NBYTES);

	// tag stack storage, undefined until written
	logic [7:0]       tag_mem [NBYTES];
	logic [IDX_W-1:0] len_mem [MAX_DEPTH];

	logic             inside_q, closing_q, mismatch_q;
	logic [IDX_W-1:0] idx_q;
	logic [DEP_W-1:0] depth_q;
	logic [2:0]       err_q;
	logic [7:0]       rd_byte_q;
	logic [IDX_W-1:0] len_top_q;
	logic             cmp_v_s2;
	logic [7:0]       byte_s2;

	logic             inside_n, closing_n, mismatch_n, cmp_v_n;
	logic [IDX_W-1:0] idx_n;
	logic [DEP_W-1:0] depth_n;
	logic [2:0]       err_n, status_n;

	logic              acc, cmp_fail, mm_eff;
	logic [DEP_W-1:0]  depth_m1;
	logic [TOP_W-1:0]  top_idx, push_idx;
	logic              tag_we, tag_re, len_we, len_re;
	logic [ADDR_W-1:0] tag_waddr, tag_raddr;
	logic [7:0]        b;
	result_item_t      res_d;
	logic              load_ready;

	assign acc        = byte_valid && byte_ready;
	assign byte_ready = load_ready;
	assign b          = byte_item.data_byte;

	assign depth_m1  = depth_q - DEP_W'(1);
	assign top_idx   = depth_m1[TOP_W-1:0];
	assign push_idx  = depth_q[TOP_W-1:0];
	assign tag_waddr = ADDR_W'(push_idx * MAX_TAG_LEN) + ADDR_W'(idx_q);
	assign tag_raddr = ADDR_W'(top_idx * MAX_TAG_LEN) + ADDR_W'(idx_q);

	assign cmp_fail = cmp_v_s2 && (rd_byte_q != byte_s2);
	assign mm_eff   = mismatch_q || cmp_fail;

	always_comb begin
		inside_n   = inside_q;
		closing_n  = closing_q;
		idx_n      = idx_q;
		depth_n    = depth_q;
		err_n      = err_q;
		mismatch_n = mm_eff;
		cmp_v_n    = 1'b0;
		tag_we     = 1'b0;
		tag_re     = 1'b0;
		len_we     = 1'b0;
		len_re     = 1'b0;
		status_n   = ST_OK;
		if (acc) begin
			if (err_q == ST_OK) begin
				if (!inside_q) begin
					if (b == CH_OPEN) begin
						inside_n   = 1'b1;
						closing_n  = 1'b0;
						idx_n      = '0;
						mismatch_n = 1'b0;
					end
				end else if (b == CH_CLOSE) begin
					if (closing_q) begin
						if (depth_q == '0 || mm_eff || idx_q != len_top_q) begin
							err_n = ST_MISMATCH;
						end else begin
							depth_n = depth_m1;
						end
					end else if (depth_q >= DEP_W'(MAX_DEPTH)) begin
						err_n = ST_DEPTH;
					end else begin
						len_we  = 1'b1;
						depth_n = depth_q + DEP_W'(1);
					end
					inside_n   = 1'b0;
					closing_n  = 1'b0;
					idx_n      = '0;
					mismatch_n = 1'b0;
				end else if (!closing_q && idx_q == '0 && b == CH_SLASH) begin
					closing_n = 1'b1;
					len_re    = 1'b1;
				end else if (idx_q >= IDX_W'(MAX_TAG_LEN)) begin
					err_n = ST_TOOLONG;
				end else begin
					if (closing_q) begin
						if (depth_q == '0 || idx_q >= len_top_q) begin
							mismatch_n = 1'b1;
						end else begin
							tag_re  = 1'b1;
							cmp_v_n = !byte_item.last;
						end
					end else if (depth_q < DEP_W'(MAX_DEPTH)) begin
						tag_we = 1'b1;
					end
					idx_n = idx_q + IDX_W'(1);
				end
			end
			if (byte_item.last) begin
				if (err_n != ST_OK) begin
					status_n = err_n;
				end else if (inside_n) begin
					status_n = ST_INCOMPLETE;
				end else if (depth_n != '0) begin
					status_n = ST_UNCLOSED;
				end
				inside_n   = 1'b0;
				closing_n  = 1'b0;
				idx_n      = '0;
				depth_n    = '0;
				err_n      = ST_OK;
				mismatch_n = 1'b0;
			end
		end
		res_d.status   = status_n;
		res_d.balanced = (status_n == ST_OK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q   <= 1'b0;
			closing_q  <= 1'b0;
			idx_q      <= '0;
			depth_q    <= '0;
			err_q      <= ST_OK;
			mismatch_q <= 1'b0;
			cmp_v_s2   <= 1'b0;
		end else begin
			inside_q   <= inside_n;
			closing_q  <= closing_n;
			idx_q      <= idx_n;
			depth_q    <= depth_n;
			err_q      <= err_n;
			mismatch_q <= mismatch_n;
			cmp_v_s2   <= cmp_v_n;
		end
	end

	always_ff @(posedge clk) begin
		byte_s2 <= b;
	end

	// writes come from opening tags, reads from closing tags: one byte never
	// does both, and a read is at least three transfers after its entry's write
	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_waddr] <= b;
		end
		if (tag_re) begin
			rd_byte_q <= tag_mem[tag_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[push_idx] <= idx_q;
		end
		if (len_re) begin
			len_top_q <= len_mem[top_idx];
		end
	end

	mtb_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (acc && byte_item.last),
		.load_item    (res_d),
		.load_ready   (load_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

	`MTB_ASSERT_NXT(a_last_gives_result, acc && byte_item.last, result_valid)
	`MTB_ASSERT_IMP(a_balanced_matches, result_valid, result_item.balanced == (result_item.status == ST_OK))
	`MTB_ASSERT_IMP(a_status_range, result_valid, result_item.status <= ST_TOOLONG)
	`MTB_ASSERT_IMP(a_depth_bound, 1'b1, depth_q <= DEP_W'(MAX_DEPTH))
	`MTB_ASSERT_IMP(a_cmp_in_close, cmp_v_s2, inside_q && closing_q)

endmodule

// File: sv/mtb_out_reg.sv
// Result output register: holds one verdict until the downstream side takes it.
// Depends on mtb_pkg.
module mtb_out_reg
	import mtb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load_valid,
	input  result_item_t load_item,
	output logic         load_ready,
	output logic         result_valid,
	input  logic         result_ready,
	output result_item_t result_item
);

	logic         valid_q;
	result_item_t item_q;

	// a new verdict may land in the same cycle the held one is taken
	assign load_ready   = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign result_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			item_q <= load_item;
		end
	end

endmodule
